// ----- hdl/joystick_jog_command_generator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Joystick jog command generator - assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_JOG_COMMAND_GENERATOR_UNIT_MACROS_SVH
`define JOYSTICK_JOG_COMMAND_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define JJCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JJCG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/jjcg_pkg.sv -----
// ----------------------------------------------------------------------------
// jjcg_pkg
// Constants shared by the joystick jog command generator.
// ----------------------------------------------------------------------------
package jjcg_pkg;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SENS       = 2'd0;
  localparam logic [1:0] REG_DEADZONE   = 2'd1;
  localparam logic [1:0] REG_FEED_LIMIT = 2'd2;
  localparam logic [1:0] REG_MAX_OUT    = 2'd3;

  localparam logic [6:0]  SENS_RESET       = 7'd50;
  localparam logic [6:0]  DEADZONE_RESET   = 7'd15;
  localparam logic [11:0] FEED_LIMIT_RESET = 12'd2000;
  localparam logic [2:0]  MAX_OUT_RESET    = 3'd3;

  localparam logic [7:0]  STICK_CENTRE = 8'd127;
  localparam logic [7:0]  STICK_DISC   = 8'd255;
  localparam logic [6:0]  SENS_MAX     = 7'd100;
  localparam logic [7:0]  DEFL_SPAN    = 8'd128;
  localparam logic [7:0]  PCT_SCALE    = 8'd100;
  localparam logic [15:0] FEED_FLOOR   = 16'd160;
  localparam logic [16:0] DIST_FLOOR   = 17'd266;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // result beat bit positions
  localparam int OB_CANCEL = 0;
  localparam int OB_REINIT = 1;
  localparam int OB_SEND   = 2;
  localparam int OB_AXIS   = 3;
  localparam int OB_NEG    = 4;
  localparam int OB_FEED   = 5;
  localparam int OB_DIST   = 21;

endpackage

// ----- hdl/joystick_jog_command_generator_unit.sv -----
// ----------------------------------------------------------------------------
// joystick_jog_command_generator_unit
// Turns one joystick sample per beat into cancel, reinit and jog commands.
// ----------------------------------------------------------------------------
// One input beat is one sampling period and gives exactly one result beat.
// A sample that sends no jog passes through the EVAL and DONE states to the
// result register. A sample that sends a jog takes three passes through the
// shared 20x8 multiplier, then 16 steps of the bit-serial divider for the
// feed and, unless the feed falls to the 10 mm/min floor, 17 more for the
// distance. s_tready is high only between samples, so no new sample is
// taken before the last result is in the output register; a finished
// result waits there while the next sample is taken in.
`include "joystick_jog_command_generator_unit_macros.svh"

module joystick_jog_command_generator_unit (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: machine_ready[0], acks_received[3:1], read_ok[4],
  //          stick_x[12:5], stick_y[20:13], zero fill [23:21]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [jjcg_pkg::IN_DATA_W-1:0]    s_tdata,
  // m_tdata: cancel_jog[0], reinit_device[1], send_jog[2], jog_axis[3],
  //          jog_negative[4], feed_q4[20:5], distance_q4[37:21], zero fill [39:38]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [jjcg_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_MUL_D = 3'd2;
  localparam logic [2:0] ST_MUL_A = 3'd3;
  localparam logic [2:0] ST_MUL_S = 3'd4;
  localparam logic [2:0] ST_DIV_F = 3'd5;
  localparam logic [2:0] ST_DIV_D = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]  state;

  logic [6:0]  sens;
  logic [6:0]  deadzone;
  logic [11:0] feed_limit;
  logic [2:0]  max_out;

  logic        jogging;
  logic [2:0]  outstanding;

  logic        in_ready;
  logic [2:0]  in_acks;
  logic        in_rok;
  logic [7:0]  in_x;
  logic [7:0]  in_y;

  logic        r_cancel;
  logic        r_reinit;
  logic        r_send;
  logic        r_axis;
  logic        r_neg;
  logic [15:0] r_feed;
  logic [16:0] r_dist;

  logic [7:0]  a_r;
  logic [19:0] prod;
  logic [29:0] num;
  logic [13:0] den;

  logic [15:0] rem;
  logic [15:0] divisor;
  logic [16:0] low;
  logic [4:0]  cnt;

  // ---- sample evaluation ----
  logic [7:0]  x_raw;
  logic [7:0]  y_raw;
  logic [7:0]  ax;
  logic [7:0]  ay;
  logic        pick_x;
  logic [7:0]  a_sel;
  logic        neg_sel;
  logic        disc;
  logic [2:0]  oc_sub;
  logic [6:0]  sens_sat;

  always_comb begin
    x_raw = (in_x >= jjcg_pkg::STICK_CENTRE) ? in_x - jjcg_pkg::STICK_CENTRE
                                             : jjcg_pkg::STICK_CENTRE - in_x;
    y_raw = (in_y >= jjcg_pkg::STICK_CENTRE) ? in_y - jjcg_pkg::STICK_CENTRE
                                             : jjcg_pkg::STICK_CENTRE - in_y;
    ax = (x_raw < {1'b0, deadzone}) ? 8'd0 : x_raw;
    ay = (y_raw < {1'b0, deadzone}) ? 8'd0 : y_raw;
    pick_x = ax > ay;
    a_sel = (pick_x ? ax : ay) - {1'b0, deadzone};
    neg_sel = pick_x ? (in_x < jjcg_pkg::STICK_CENTRE) : (in_y < jjcg_pkg::STICK_CENTRE);
    disc = (in_x == jjcg_pkg::STICK_DISC) && (in_y == jjcg_pkg::STICK_DISC);
    oc_sub = (outstanding > in_acks) ? outstanding - in_acks : 3'd0;
    sens_sat = (sens > jjcg_pkg::SENS_MAX) ? jjcg_pkg::SENS_MAX : sens;
  end

  // ---- shared multiplier ----
  logic [19:0] mul_x;
  logic [7:0]  mul_y;
  logic [27:0] mul_p;

  always_comb begin
    case (state)
      ST_MUL_D: begin
        mul_x = {12'd0, jjcg_pkg::DEFL_SPAN - {1'b0, deadzone}};
        mul_y = jjcg_pkg::PCT_SCALE;
      end
      ST_MUL_A: begin
        mul_x = {8'd0, feed_limit};
        mul_y = a_r;
      end
      ST_MUL_S: begin
        mul_x = prod;
        mul_y = {1'b0, sens_sat};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    mul_p = mul_x * mul_y;
  end

  // ---- shared divider step (one quotient bit per cycle) ----
  logic [16:0] div_t;
  logic [16:0] div_diff;
  logic        div_ge;
  logic [15:0] rem_next;
  logic [16:0] low_next;
  logic [31:0] num5;

  always_comb begin
    div_t    = {rem, low[16]};
    div_diff = div_t - {1'b0, divisor};
    div_ge   = div_t >= {1'b0, divisor};
    rem_next = div_ge ? div_diff[15:0] : div_t[15:0];
    low_next = {low[15:0], div_ge};
    num5     = {2'b00, num} + {num, 2'b00};
  end

  assign s_tready = (state == ST_IDLE);
  assign pready   = 1'b1;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      sens       <= jjcg_pkg::SENS_RESET;
      deadzone   <= jjcg_pkg::DEADZONE_RESET;
      feed_limit <= jjcg_pkg::FEED_LIMIT_RESET;
      max_out    <= jjcg_pkg::MAX_OUT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        jjcg_pkg::REG_SENS:       sens       <= pwdata[6:0];
        jjcg_pkg::REG_DEADZONE:   deadzone   <= pwdata[6:0];
        jjcg_pkg::REG_FEED_LIMIT: feed_limit <= pwdata[11:0];
        jjcg_pkg::REG_MAX_OUT:    max_out    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      jjcg_pkg::REG_SENS:       prdata = {25'd0, sens};
      jjcg_pkg::REG_DEADZONE:   prdata = {25'd0, deadzone};
      jjcg_pkg::REG_FEED_LIMIT: prdata = {20'd0, feed_limit};
      jjcg_pkg::REG_MAX_OUT:    prdata = {29'd0, max_out};
      default:                  prdata = '0;
    endcase
  end

  // ---- control state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      jogging     <= 1'b0;
      outstanding <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_EVAL;
        end
        ST_EVAL: begin
          state <= ST_DONE;
          if (!in_ready) begin
            jogging     <= 1'b0;
            outstanding <= '0;
          end else begin
            outstanding <= oc_sub;
            if (!in_rok) begin
            end else if (disc || (ax == 8'd0 && ay == 8'd0)) begin
              jogging     <= 1'b0;
              outstanding <= '0;
            end else if (oc_sub >= max_out) begin
            end else begin
              jogging     <= 1'b1;
              outstanding <= oc_sub + 3'd1;
              state       <= ST_MUL_D;
            end
          end
        end
        ST_MUL_D: state <= ST_MUL_A;
        ST_MUL_A: state <= ST_MUL_S;
        ST_MUL_S: state <= ST_DIV_F;
        ST_DIV_F: begin
          if (cnt == 5'd0) begin
            state <= (low_next[15:0] < jjcg_pkg::FEED_FLOOR) ? ST_DONE : ST_DIV_D;
          end
        end
        ST_DIV_D: begin
          if (cnt == 5'd0) state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          in_ready <= s_tdata[0];
          in_acks  <= s_tdata[3:1];
          in_rok   <= s_tdata[4];
          in_x     <= s_tdata[12:5];
          in_y     <= s_tdata[20:13];
        end
      end
      ST_EVAL: begin
        r_cancel <= 1'b0;
        r_reinit <= 1'b0;
        r_send   <= 1'b0;
        r_axis   <= 1'b0;
        r_neg    <= 1'b0;
        r_feed   <= '0;
        r_dist   <= '0;
        a_r      <= a_sel;
        if (!in_ready) begin
          r_cancel <= jogging;
        end else if (!in_rok) begin
          r_reinit <= 1'b1;
        end else if (disc) begin
          r_cancel <= jogging;
          r_reinit <= 1'b1;
        end else if (ax == 8'd0 && ay == 8'd0) begin
          r_cancel <= jogging;
        end else if (oc_sub < max_out) begin
          r_send <= 1'b1;
          r_axis <= !pick_x;
          r_neg  <= neg_sel;
        end
      end
      ST_MUL_D: den  <= mul_p[13:0];
      ST_MUL_A: prod <= mul_p[19:0];
      ST_MUL_S: begin
        // feed numerator: feed_limit * a * sens * 16
        num     <= {mul_p[25:0], 4'b0000};
        rem     <= {2'd0, mul_p[25:12]};
        low     <= {mul_p[11:0], 5'b00000};
        divisor <= {2'b00, den};
        cnt     <= 5'd15;
      end
      ST_DIV_F: begin
        rem <= rem_next;
        low <= low_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          if (low_next[15:0] < jjcg_pkg::FEED_FLOOR) begin
            r_feed <= jjcg_pkg::FEED_FLOOR;
            r_dist <= jjcg_pkg::DIST_FLOOR;
          end else begin
            r_feed  <= low_next[15:0];
            rem     <= {1'b0, num5[31:17]};
            low     <= num5[16:0];
            divisor <= {2'b00, den} + {1'b0, den, 1'b0};
            cnt     <= 5'd16;
          end
        end
      end
      ST_DIV_D: begin
        rem <= rem_next;
        low <= low_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) r_dist <= low_next;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {2'b00, r_dist, r_feed, r_neg, r_axis, r_send, r_reinit, r_cancel};
        end
      end
      default: ;
    endcase
  end

  // ---- assertions ----
  `JJCG_ASSERT_NOW(a_div_rem_below, (state == ST_DIV_F || state == ST_DIV_D),
    (rem < divisor), "divider remainder not below divisor")
  `JJCG_ASSERT_NOW(a_feed_floor, (m_tvalid && m_tdata[jjcg_pkg::OB_SEND]),
    (m_tdata[jjcg_pkg::OB_DIST-1:jjcg_pkg::OB_FEED] >= jjcg_pkg::FEED_FLOOR),
    "jog sent below feed floor")
  `JJCG_ASSERT_NOW(a_idle_fields, (m_tvalid && !m_tdata[jjcg_pkg::OB_SEND]),
    (m_tdata[37:jjcg_pkg::OB_AXIS] == 35'd0), "jog fields set without send")
  `JJCG_ASSERT_NXT(a_one_at_a_time, (s_tvalid && s_tready), (!s_tready),
    "sample taken while busy")

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb - joystick jog command generator testbench
// Drives joystick samples on the input stream and programs the four control
// registers over APB. A scoreboard works out the command that each accepted
// sample should give and checks every result beat, field by field, against
// the oldest one still due. A directed set runs at the reset settings, then
// random phases at extreme and random settings, with gaps on the input side
// and stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jjcg_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int FLOOR_Q4    = 160;
  localparam int REPORT_CAP  = 50;

  // lowest bit first: ready, acks, read_ok, x, y, pad
  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] y;
    logic [7:0] x;
    logic       read_ok;
    logic [2:0] acks;
    logic       ready;
  } stick_beat_t;

  // lowest bit first: cancel, reinit, send, axis, neg, feed, distance, pad
  typedef struct packed {
    logic [1:0]  pad;
    logic [16:0] distance;
    logic [15:0] feed;
    logic        neg;
    logic        axis;
    logic        send;
    logic        reinit;
    logic        cancel;
  } jog_cmd_t;

  class jog_scoreboard;
    logic [6:0]  sens;
    logic [6:0]  dz;
    logic [11:0] feed_max;
    logic [2:0]  out_limit;
    bit          jogging;
    logic [2:0]  in_flight;
    jog_cmd_t    due_cmds[$];
    int          errors;

    function new();
      sens      = SENS_RESET;
      dz        = DEADZONE_RESET;
      feed_max  = FEED_LIMIT_RESET;
      out_limit = MAX_OUT_RESET;
      jogging   = 1'b0;
      in_flight = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_SENS:       sens      = val[6:0];
        REG_DEADZONE:   dz        = val[6:0];
        REG_FEED_LIMIT: feed_max  = val[11:0];
        REG_MAX_OUT:    out_limit = val[2:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_SENS:       return 32'(sens);
        REG_DEADZONE:   return 32'(dz);
        REG_FEED_LIMIT: return 32'(feed_max);
        default:        return 32'(out_limit);
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function void drop_jog(inout jog_cmd_t c);
      if (jogging) begin
        c.cancel  = 1'b1;
        jogging   = 1'b0;
        in_flight = '0;
      end
    endfunction

    function void note_sample(stick_beat_t b);
      jog_cmd_t        c;
      int              dx, dy, ax, ay, defl, pct;
      bit              on_x;
      longint unsigned num, den, fq;
      c = '0;
      if (!b.ready) begin
        drop_jog(c);
      end else begin
        in_flight = (in_flight > b.acks) ? in_flight - b.acks : 3'd0;
        if (!b.read_ok) begin
          c.reinit = 1'b1;
        end else if (b.x == 8'hFF && b.y == 8'hFF) begin
          drop_jog(c);
          c.reinit = 1'b1;
        end else begin
          dx = int'(b.x) - 127;
          dy = int'(b.y) - 127;
          ax = (dx < 0) ? -dx : dx;
          ay = (dy < 0) ? -dy : dy;
          if (ax < int'(dz)) begin
            dx = 0;
            ax = 0;
          end
          if (ay < int'(dz)) begin
            dy = 0;
            ay = 0;
          end
          if (dx == 0 && dy == 0) begin
            drop_jog(c);
          end else if (in_flight < out_limit) begin
            on_x = ax > ay;
            defl = (on_x ? ax : ay) - int'(dz);
            pct  = (sens > 7'd100) ? 100 : int'(sens);
            num  = longint'(feed_max) * defl * pct * 16;
            den  = (128 - int'(dz)) * 100;
            fq   = num / den;
            c.send = 1'b1;
            c.axis = !on_x;
            c.neg  = on_x ? (dx < 0) : (dy < 0);
            if (fq < FLOOR_Q4) begin
              c.feed     = 16'(FLOOR_Q4);
              c.distance = 17'((FLOOR_Q4 * 5) / 3);
            end else begin
              c.feed     = fq[15:0];
              c.distance = 17'((num * 5) / (den * 3));
            end
            jogging   = 1'b1;
            in_flight = in_flight + 3'd1;
          end
        end
      end
      due_cmds.push_back(c);
    endfunction

    task check_result(jog_cmd_t got);
      jog_cmd_t want;
      if (due_cmds.size() == 0) begin
        report($sformatf("result beat 0x%0h with nothing due", got));
      end else begin
        want = due_cmds.pop_front();
        cmp("cancel_jog", got.cancel, want.cancel);
        cmp("reinit_device", got.reinit, want.reinit);
        cmp("send_jog", got.send, want.send);
        cmp("jog_axis", got.axis, want.axis);
        cmp("jog_negative", got.neg, want.neg);
        cmp("feed_q4", got.feed, want.feed);
        cmp("distance_q4", got.distance, want.distance);
        cmp("zero fill", got.pad, want.pad);
      end
    endtask

    function int pending();
      return due_cmds.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [3:0]            paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;

  jog_scoreboard sb;
  int            idle_cycles = 0;
  bit            beat_seen;
  int            sink_mode   = 0;
  int            stall_left  = 0;

  joystick_jog_command_generator_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // output side stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (sink_mode != 0 && $urandom_range(0, sink_mode == 1 ? 2 : 9) == 0) begin
      stall_left <= $urandom_range(0, sink_mode == 1 ? 3 : 40);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      beat_seen = 1'b0;
      if (s_tvalid && s_tready) begin
        sb.note_sample(s_tdata);
        beat_seen = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        beat_seen = 1'b1;
      end
      if (psel && penable && pready) begin
        if (pwrite)
          sb.write_reg(paddr[3:2], pwdata);
        else if (prdata !== sb.reg_value(paddr[3:2]))
          sb.report($sformatf("register %0d read 0x%0h expected 0x%0h",
                              paddr[3:2], prdata, sb.reg_value(paddr[3:2])));
        beat_seen = 1'b1;
      end
      idle_cycles = beat_seen ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic stick_beat_t mk(bit rdy, int acks, bit rok, int x, int y);
    stick_beat_t b;
    b         = '0;
    b.ready   = rdy;
    b.acks    = 3'(acks);
    b.read_ok = rok;
    b.x       = 8'(x);
    b.y       = 8'(y);
    return b;
  endfunction

  // centre, either side of the deadzone edge, the ends, or anywhere
  function automatic logic [7:0] stick_value();
    int v, off, dir;
    dir = $urandom_range(0, 1) ? 1 : -1;
    off = int'(sb.dz) + int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 5))
      0:       v = 127;
      1:       v = 127 + dir * off;
      2:       v = $urandom_range(0, 1) ? 255 : 0;
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic stick_beat_t random_beat();
    stick_beat_t b;
    int          roll;
    b         = '0;
    roll      = $urandom_range(0, 99);
    b.ready   = (roll >= 6);
    b.read_ok = (roll < 6 || roll >= 12);
    b.acks    = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1));
    if ($urandom_range(0, 29) == 0) begin
      b.x = 8'hFF;
      b.y = 8'hFF;
    end else begin
      b.x = stick_value();
      b.y = stick_value();
    end
    return b;
  endfunction

  task automatic drive_beat(input stick_beat_t b);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic run_samples(input int count, input int gap_mode);
    int burst, gap, i;
    burst = $urandom_range(1, 16);
    for (i = 0; i < count; i++) begin
      drive_beat(random_beat());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        gap   = (gap_mode == 0) ? 0 : $urandom_range(0, gap_mode == 1 ? 3 : 12);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          s_tdata  <= IN_DATA_W'($urandom);
          repeat (gap) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_back();
    int i;
    for (i = 0; i < 4; i++) apb_access(2'(i), 1'b0, '0);
  endtask

  // upper bits of each write carry junk, the register keeps its own width
  task automatic configure(input int sens, input int dz, input int feed, input int lim);
    apb_access(REG_SENS, 1'b1, (32'($urandom) << 7) | 32'(sens));
    apb_access(REG_DEADZONE, 1'b1, (32'($urandom) << 7) | 32'(dz));
    apb_access(REG_FEED_LIMIT, 1'b1, (32'($urandom) << 12) | 32'(feed));
    apb_access(REG_MAX_OUT, 1'b1, (32'($urandom) << 3) | 32'(lim));
    read_back();
  endtask

  task automatic drain();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    stick_beat_t directed[$];
    int          ph;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(mk(0, 0, 1, 127, 127));  // not ready, idle
    directed.push_back(mk(1, 0, 0, 127, 127));  // read failure
    directed.push_back(mk(1, 0, 1, 255, 255));  // disconnect, idle
    directed.push_back(mk(1, 0, 1, 127, 127));  // centred
    directed.push_back(mk(1, 0, 1, 255, 127));  // X full positive
    directed.push_back(mk(1, 0, 1, 0, 127));    // X full negative
    directed.push_back(mk(1, 0, 1, 127, 0));    // Y negative, at limit now
    directed.push_back(mk(1, 0, 1, 127, 255));  // held by flow control
    directed.push_back(mk(1, 7, 1, 127, 255));  // acks saturate
    directed.push_back(mk(1, 0, 1, 200, 54));   // tie goes to Y
    directed.push_back(mk(1, 2, 1, 143, 127));  // just past deadzone, feed floor
    directed.push_back(mk(1, 0, 1, 142, 127));  // on the deadzone edge
    directed.push_back(mk(1, 0, 1, 141, 113));  // released while jogging
    directed.push_back(mk(1, 0, 1, 255, 0));    // X wins by one
    directed.push_back(mk(0, 5, 0, 3, 250));    // not ready while jogging
    directed.push_back(mk(1, 0, 1, 0, 0));      // tie, both negative
    directed.push_back(mk(1, 0, 1, 255, 255));  // disconnect while jogging
    directed.push_back(mk(1, 1, 1, 90, 200));
    directed.push_back(mk(1, 0, 0, 255, 255));  // read failure wins over disconnect
    directed.push_back(mk(1, 3, 1, 127, 127));
    directed.push_back(mk(1, 4, 1, 170, 60));
    directed.push_back(mk(1, 7, 1, 255, 255));
    foreach (directed[i]) drive_beat(directed[i]);
    s_tvalid <= 1'b0;
    drain();
    read_back();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(0, 0, 1, 1);
        1: configure(127, 127, 4095, 7);
        2: configure(100, 0, 4000, 7);
        3: configure(73, 40, 0, 0);
        4: configure(101, 126, 1, 2);
        default: configure($urandom_range(0, 127), $urandom_range(0, 60),
                           $urandom_range(0, 4095), $urandom_range(1, 7));
      endcase
      sink_mode = ph % 3;
      run_samples(80, (ph + 1) % 3);
      drain();
    end

    repeat (60) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/jjcg_pkg.sv
hdl/joystick_jog_command_generator_unit.sv
verif/tb.sv
